// ----- hw/rtl/pft_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pft_pkg
// Shared widths, defaults and controller/datapath handshake structs for the
// polygon fan triangulator.
// ---------------------------------------------------------------------------
package pft_pkg;

  localparam int COORD_W        = 16;
  localparam int VERTEX_W       = 6;
  localparam int COLOR_W        = 8;
  localparam int MAX_POINTS_DEF = 64;
  localparam int MAX_TRIS       = 62;
  localparam int MIN_POINTS     = 3;
  localparam int DIFF_W         = COORD_W + 1;
  localparam int PROD_W         = 2 * DIFF_W;

  // controller -> datapath
  typedef struct packed {
    logic accept;      // latch incoming vertex
    logic sel_close;   // corner closes onto the first vertex
    logic diff;        // register coordinate differences
    logic mul;         // register cross-product terms
    logic sign;        // classify corner, update concave tally
    logic advance;     // shift point window, bump count
    logic init_walk;   // set up the fan walker
    logic walk;        // step the walker one vertex
    logic take_a;      // latch anchor color
    logic take_s;      // latch second vertex
    logic take_t;      // latch third vertex
    logic emit_step;   // slide the triangle window
    logic clear;       // drop polygon state
  } pft_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic room;        // another vertex can be kept
    logic ge2;         // at least two vertices kept
    logic last;        // latched item ended the polygon
    logic few;         // fewer than three vertices kept
    logic two_plus;    // two or more concave corners
    logic seek_hit;    // walker sits on the anchor
    logic last_tri;    // current triangle ends the fan
  } pft_status_t;

endpackage

// ----- hw/rtl/polygon_fan_triangulator_top.sv -----
`timescale 1ns / 1ps
// Sequence: a vertex that adds a corner passes accept, difference,
// multiply, sign and advance; the first two and dropped ones: accept, advance.
// The last vertex adds a close check (test, difference, multiply, sign,
// decide), an anchor seek and the second/third loads; then one triangle per
// cycle while out_stall is low, for n-2 (at most MAX_TRIS), then a clear.
// Reset (rst, synchronous): polygon cleared, color_count = 1.
// ---------------------------------------------------------------------------
// polygon_fan_triangulator_top
// Streams polygon vertices in, classifies corners and emits the triangle fan.
// ---------------------------------------------------------------------------
module polygon_fan_triangulator_top #(
  parameter int MAX_POINTS = pft_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [pft_pkg::COORD_W-1:0]  x_coord,
  input  logic signed [pft_pkg::COORD_W-1:0]  y_coord,
  input  logic                                last_point,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic        [pft_pkg::VERTEX_W-1:0] anchor_vertex,
  output logic        [pft_pkg::VERTEX_W-1:0] second_vertex,
  output logic        [pft_pkg::VERTEX_W-1:0] third_vertex,
  output logic        [pft_pkg::COLOR_W-1:0]  anchor_color,
  output logic        [pft_pkg::COLOR_W-1:0]  second_color,
  output logic        [pft_pkg::COLOR_W-1:0]  third_color,
  output logic                                fan_kind,
  output logic                                last_triangle,
  input  logic                                cfg_we,
  input  logic        [pft_pkg::COLOR_W-1:0]  cfg_wdata
);
  import pft_pkg::*;

  pft_cmd_t    cmd;
  pft_status_t st;

  pft_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  pft_dpath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .x_coord       (x_coord),
    .y_coord       (y_coord),
    .last_point    (last_point),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .anchor_vertex (anchor_vertex),
    .second_vertex (second_vertex),
    .third_vertex  (third_vertex),
    .anchor_color  (anchor_color),
    .second_color  (second_color),
    .third_color   (third_color),
    .fan_kind      (fan_kind),
    .last_triangle (last_triangle)
  );

endmodule

// ----- hw/rtl/pft_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pft_ctrl
// Sequencer: per-vertex corner check, polygon close, anchor seek and
// triangle emission.
// ---------------------------------------------------------------------------
module pft_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  pft_pkg::pft_status_t st,
  output pft_pkg::pft_cmd_t    cmd
);
  import pft_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_DIFF    = 12'b0000_0000_0010,
    S_MUL     = 12'b0000_0000_0100,
    S_SIGN    = 12'b0000_0000_1000,
    S_ADVANCE = 12'b0000_0001_0000,
    S_TEST    = 12'b0000_0010_0000,
    S_DECIDE  = 12'b0000_0100_0000,
    S_SEEK    = 12'b0000_1000_0000,
    S_LOAD_S  = 12'b0001_0000_0000,
    S_LOAD_T  = 12'b0010_0000_0000,
    S_EMIT    = 12'b0100_0000_0000,
    S_CLEAR   = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;
  logic   close, close_next;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_EMIT);

  always_comb begin
    state_next = state;
    close_next = close;
    cmd        = '0;
    cmd.sel_close = close;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          close_next = 1'b0;
          state_next = (st.room && st.ge2) ? S_DIFF : S_ADVANCE;
        end
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SIGN;
      end
      S_SIGN: begin
        cmd.sign   = 1'b1;
        state_next = close ? S_DECIDE : S_ADVANCE;
      end
      S_ADVANCE: begin
        cmd.advance = 1'b1;
        state_next  = st.last ? S_TEST : S_IDLE;
      end
      S_TEST: begin
        if (st.few) begin
          state_next = S_CLEAR;
        end else begin
          close_next = 1'b1;
          state_next = S_DIFF;
        end
      end
      S_DECIDE: begin
        if (st.two_plus) begin
          state_next = S_CLEAR;
        end else begin
          cmd.init_walk = 1'b1;
          state_next    = S_SEEK;
        end
      end
      S_SEEK: begin
        cmd.walk = 1'b1;
        if (st.seek_hit) begin
          cmd.take_a = 1'b1;
          state_next = S_LOAD_S;
        end
      end
      S_LOAD_S: begin
        cmd.walk   = 1'b1;
        cmd.take_s = 1'b1;
        state_next = S_LOAD_T;
      end
      S_LOAD_T: begin
        cmd.walk   = 1'b1;
        cmd.take_t = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_stall) begin
          if (st.last_tri) begin
            state_next = S_CLEAR;
          end else begin
            cmd.walk      = 1'b1;
            cmd.emit_step = 1'b1;
          end
        end
      end
      S_CLEAR: begin
        cmd.clear  = 1'b1;
        close_next = 1'b0;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      close <= 1'b0;
    end else begin
      state <= state_next;
      close <= close_next;
    end
  end

endmodule

// ----- hw/rtl/pft_dpath.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pft_dpath
// Point window, cross-product unit, concave tally, color register and the
// fan walker that produces triangle vertex and color indices.
// ---------------------------------------------------------------------------
module pft_dpath #(
  parameter int MAX_POINTS = pft_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pft_pkg::pft_cmd_t                   cmd,
  output pft_pkg::pft_status_t                st,
  input  logic signed [pft_pkg::COORD_W-1:0]  x_coord,
  input  logic signed [pft_pkg::COORD_W-1:0]  y_coord,
  input  logic                                last_point,
  input  logic                                cfg_we,
  input  logic        [pft_pkg::COLOR_W-1:0]  cfg_wdata,
  output logic        [pft_pkg::VERTEX_W-1:0] anchor_vertex,
  output logic        [pft_pkg::VERTEX_W-1:0] second_vertex,
  output logic        [pft_pkg::VERTEX_W-1:0] third_vertex,
  output logic        [pft_pkg::COLOR_W-1:0]  anchor_color,
  output logic        [pft_pkg::COLOR_W-1:0]  second_color,
  output logic        [pft_pkg::COLOR_W-1:0]  third_color,
  output logic                                fan_kind,
  output logic                                last_triangle
);
  import pft_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int IDX_W = $clog2(MAX_POINTS);

  // point window
  logic signed [COORD_W-1:0] first_x, first_y;
  logic signed [COORD_W-1:0] older_x, older_y;
  logic signed [COORD_W-1:0] newer_x, newer_y;
  logic signed [COORD_W-1:0] cur_x, cur_y;
  logic                      last_r, kept_r;
  logic [CNT_W-1:0]          count;
  logic [1:0]                concave;
  logic [IDX_W-1:0]          anchor;
  logic [COLOR_W-1:0]        color_count;

  // cross product
  logic signed [DIFF_W-1:0]  d1x, d1y, d2x, d2y;
  logic signed [PROD_W-1:0]  p1, p2;
  logic signed [PROD_W:0]    z;
  logic signed [COORD_W-1:0] c_x, c_y;

  // fan walker
  logic [CNT_W-1:0]   w, w_next;
  logic [COLOR_W-1:0] cw, cw_next, modulus;
  logic [CNT_W-1:0]   a_idx, s_idx, t_idx, left, tris_raw;
  logic [COLOR_W-1:0] a_col, s_col, t_col;
  logic               kind;

  assign c_x = cmd.sel_close ? first_x : cur_x;
  assign c_y = cmd.sel_close ? first_y : cur_y;

  assign z = (PROD_W + 1)'(p1) - (PROD_W + 1)'(p2);

  assign modulus = (color_count == '0) ? COLOR_W'(1) : color_count;

  always_comb begin
    if (w + CNT_W'(1) == count) begin
      w_next  = '0;
      cw_next = '0;
    end else begin
      w_next  = w + CNT_W'(1);
      cw_next = ((COLOR_W + 1)'(cw) + (COLOR_W + 1)'(1) == {1'b0, modulus}) ?
                '0 : cw + COLOR_W'(1);
    end
  end

  assign tris_raw = count - CNT_W'(2);

  assign st.room     = (count < CNT_W'(MAX_POINTS));
  assign st.ge2      = (count >= CNT_W'(2));
  assign st.last     = last_r;
  assign st.few      = (count < CNT_W'(MIN_POINTS));
  assign st.two_plus = concave[1];
  assign st.seek_hit = (w == a_idx);
  assign st.last_tri = (left == CNT_W'(1));

  // color register
  always_ff @(posedge clk) begin
    if (rst) begin
      color_count <= COLOR_W'(1);
    end else if (cfg_we) begin
      color_count <= cfg_wdata;
    end
  end

  // control-side polygon state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count   <= '0;
      concave <= '0;
      anchor  <= '0;
    end else begin
      if (cmd.advance && kept_r) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.sign && z[PROD_W]) begin
        if (concave == 2'd0) begin
          anchor <= IDX_W'(count - CNT_W'(1));
        end
        if (!concave[1]) begin
          concave <= concave + 2'd1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_x  <= x_coord;
      cur_y  <= y_coord;
      last_r <= last_point;
      kept_r <= st.room;
    end
    if (cmd.advance && kept_r) begin
      if (count == '0) begin
        first_x <= cur_x;
        first_y <= cur_y;
      end
      older_x <= newer_x;
      older_y <= newer_y;
      newer_x <= cur_x;
      newer_y <= cur_y;
    end
    if (cmd.diff) begin
      d1x <= DIFF_W'(older_x) - DIFF_W'(newer_x);
      d1y <= DIFF_W'(older_y) - DIFF_W'(newer_y);
      d2x <= DIFF_W'(newer_x) - DIFF_W'(c_x);
      d2y <= DIFF_W'(newer_y) - DIFF_W'(c_y);
    end
    if (cmd.mul) begin
      p1 <= d1x * d2y;
      p2 <= d1y * d2x;
    end
    if (cmd.init_walk) begin
      w     <= '0;
      cw    <= '0;
      kind  <= (concave == 2'd1);
      a_idx <= (concave == 2'd1) ? CNT_W'(anchor) : '0;
      left  <= (8'(tris_raw) > 8'(MAX_TRIS)) ? CNT_W'(MAX_TRIS) : tris_raw;
    end else if (cmd.walk) begin
      w  <= w_next;
      cw <= cw_next;
    end
    if (cmd.take_a) begin
      a_col <= cw;
    end
    if (cmd.take_s) begin
      s_idx <= w;
      s_col <= cw;
    end
    if (cmd.take_t) begin
      t_idx <= w;
      t_col <= cw;
    end
    if (cmd.emit_step) begin
      s_idx <= t_idx;
      s_col <= t_col;
      t_idx <= w;
      t_col <= cw;
      left  <= left - CNT_W'(1);
    end
  end

  assign anchor_vertex = VERTEX_W'(a_idx);
  assign second_vertex = VERTEX_W'(s_idx);
  assign third_vertex  = VERTEX_W'(t_idx);
  assign anchor_color  = a_col;
  assign second_color  = s_col;
  assign third_color   = t_col;
  assign fan_kind      = kind;
  assign last_triangle = st.last_tri;

endmodule
